### rtl/lzss_pkg.sv
// lzss_pkg: shared constants and state type for the lzss halfword decompressor
// no dependencies; imported by lzss_halfword_decompressor
package lzss_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int MIN_MATCH_DEF    = 3;
    localparam int COUNT_WIDTH_DEF  = 24;

    localparam int HALF_W     = 16;
    localparam int DIST_W     = 12;
    localparam int LEN_FIELD_W = 4;
    localparam int LEN_W      = 5;
    localparam int FLAG_POS_W = 4;
    localparam int LOW_BYTE_W = 8;

    typedef enum logic [2:0] {
        ST_HDR_LO,
        ST_HDR_HI,
        ST_FLAGS,
        ST_ITEM,
        ST_COPY_RD,
        ST_COPY_WR
    } lzss_state_t;

endpackage

### rtl/lzss_ram.sv
// lzss_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module lzss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lzss_halfword_decompressor.sv
// lzss_halfword_decompressor: lzss stream decoder, halfword literals and back-references
// depends on lzss_pkg and lzss_ram (history window)
// header and flag items are always taken; a literal is on the output the next cycle
// each copied halfword is read (ST_COPY_RD), then written back (ST_COPY_WR) once slot_free
// throughput is set by the single history read port and the read/write alternation
// rst_n clears fsm, flag, count, valid regs; history ram is not cleared, needs no clearing
module lzss_halfword_decompressor #(
    parameter int WINDOW_DEPTH = lzss_pkg::WINDOW_DEPTH_DEF,
    parameter int MIN_MATCH    = lzss_pkg::MIN_MATCH_DEF,
    parameter int COUNT_WIDTH  = lzss_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lzss_pkg::HALF_W-1:0] in_halfword,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lzss_pkg::HALF_W-1:0] out_halfword,
    output logic                        out_last
);

    import lzss_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CMP_W = (COUNT_WIDTH > AW) ? COUNT_WIDTH : AW;

    lzss_state_t state_reg, state_next;

    logic [LOW_BYTE_W-1:0]  low_byte_reg, low_byte_next;
    logic [HALF_W-1:0]      flag_word_reg, flag_word_next;
    logic [FLAG_POS_W-1:0]  flag_pos_reg, flag_pos_next;
    logic [COUNT_WIDTH-1:0] remaining_reg, remaining_next;
    logic [COUNT_WIDTH-1:0] produced_reg, produced_next;
    logic [DIST_W-1:0]      dist_m1_reg, dist_m1_next;
    logic [LEN_W-1:0]       copy_len_reg, copy_len_next;
    logic                   zero_ref_reg, zero_ref_next;

    logic              out_valid_reg, out_valid_next;
    logic [HALF_W-1:0] out_halfword_reg, out_halfword_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              slot_free;
    logic              emit;
    logic [HALF_W-1:0] emit_data;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [HALF_W-1:0] ram_rdata;
    logic [CMP_W-1:0]  produced_ext;
    logic [LEN_W-1:0]  tok_len;
    logic [COUNT_WIDTH-1:0] rem_after;
    logic [FLAG_POS_W-1:0]  pos_inc;
    logic [COUNT_WIDTH-1:0] header_count;

    assign slot_free    = !out_valid_reg || out_ready;
    assign accept       = in_valid && in_ready;
    assign produced_ext = CMP_W'(produced_reg);
    assign ram_raddr    = produced_ext[AW-1:0] - AW'(dist_m1_reg) - AW'(1);
    assign tok_len      = LEN_W'(in_halfword[LEN_FIELD_W-1:0]) + LEN_W'(MIN_MATCH);
    assign rem_after    = emit ? (remaining_reg - COUNT_WIDTH'(1)) : remaining_reg;
    assign pos_inc      = flag_pos_reg + FLAG_POS_W'(1);
    assign header_count = COUNT_WIDTH'({in_halfword, low_byte_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HDR_LO;
            low_byte_reg  <= '0;
            flag_word_reg <= '0;
            flag_pos_reg  <= '0;
            remaining_reg <= '0;
            produced_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_byte_reg  <= low_byte_next;
            flag_word_reg <= flag_word_next;
            flag_pos_reg  <= flag_pos_next;
            remaining_reg <= remaining_next;
            produced_reg  <= produced_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_m1_reg      <= dist_m1_next;
        copy_len_reg     <= copy_len_next;
        zero_ref_reg     <= zero_ref_next;
        out_halfword_reg <= out_halfword_next;
        out_last_reg     <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        low_byte_next  = low_byte_reg;
        flag_word_next = flag_word_reg;
        flag_pos_next  = flag_pos_reg;
        remaining_next = remaining_reg;
        produced_next  = produced_reg;
        dist_m1_next   = dist_m1_reg;
        copy_len_next  = copy_len_reg;
        zero_ref_next  = zero_ref_reg;
        in_ready       = 1'b0;
        emit           = 1'b0;
        emit_data      = in_halfword;
        ram_re         = 1'b0;

        case (state_reg)
            ST_HDR_LO:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    low_byte_next = in_halfword[HALF_W-1:LOW_BYTE_W];
                    state_next    = ST_HDR_HI;
                end
            end
            ST_HDR_HI:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    remaining_next = header_count;
                    produced_next  = '0;
                    flag_word_next = '0;
                    flag_pos_next  = '0;
                    state_next     = (header_count == '0) ? ST_HDR_LO : ST_FLAGS;
                end
            end
            ST_FLAGS:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    flag_word_next = in_halfword;
                    flag_pos_next  = '0;
                    state_next     = ST_ITEM;
                end
            end
            ST_ITEM:
            begin
                in_ready = slot_free;
                if (accept)
                begin
                    if (!flag_word_reg[flag_pos_reg])
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        dist_m1_next  = in_halfword[HALF_W-1:LEN_FIELD_W];
                        copy_len_next = (COUNT_WIDTH'(tok_len) > remaining_reg)
                                        ? remaining_reg[LEN_W-1:0] : tok_len;
                        state_next    = ST_COPY_RD;
                    end
                end
            end
            ST_COPY_RD:
            begin
                ram_re        = 1'b1;
                zero_ref_next = (CMP_W'(dist_m1_reg) >= produced_ext);
                state_next    = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                emit_data = zero_ref_reg ? '0 : ram_rdata;
                if (slot_free)
                begin
                    emit          = 1'b1;
                    copy_len_next = copy_len_reg - LEN_W'(1);
                    state_next    = ST_COPY_RD;
                end
            end
            default:
            begin
                state_next = ST_HDR_LO;
            end
        endcase

        if (emit)
        begin
            remaining_next = rem_after;
            produced_next  = produced_reg + COUNT_WIDTH'(1);
        end

        // item complete: literal, or last halfword of a token copy
        if ((state_reg == ST_ITEM && emit) ||
            (state_reg == ST_COPY_WR && emit && copy_len_reg == LEN_W'(1)))
        begin
            flag_pos_next = pos_inc;
            if (rem_after == '0)
            begin
                state_next     = ST_HDR_LO;
                flag_pos_next  = '0;
                flag_word_next = '0;
            end
            else if (pos_inc == '0)
            begin
                state_next = ST_FLAGS;
            end
            else
            begin
                state_next = ST_ITEM;
            end
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_halfword_next = out_halfword_reg;
        out_last_next     = out_last_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_halfword_next = emit_data;
            out_last_next     = (rem_after == '0);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    lzss_ram #(
        .WIDTH (HALF_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (emit),
        .waddr (produced_ext[AW-1:0]),
        .wdata (emit_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign out_halfword = out_halfword_reg;
    assign out_last     = out_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("pending output item overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(emit && ram_re))
        else $error("history read and write in the same cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY_RD || state_reg == ST_COPY_WR) |-> (copy_len_reg != '0))
        else $error("copy running with zero length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITEM || state_reg == ST_COPY_RD) |-> (remaining_reg != '0))
        else $error("item processing with nothing remaining");
`endif

endmodule

### tb/sv/lzss_checker.sv
// lzss_checker: watches both channels of the halfword decompressor, predicts every output item
// and compares it with what the block delivers; hands the pending and mismatch counts upwards
// depends on lzss_pkg for widths and the default window, match and count sizes
module lzss_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [lzss_pkg::HALF_W-1:0] in_halfword,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [lzss_pkg::HALF_W-1:0] out_halfword,
    input  logic                        out_last,
    output int                          pending,
    output int                          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = lzss_pkg::WINDOW_DEPTH_DEF;
    localparam int CW  = lzss_pkg::COUNT_WIDTH_DEF;
    localparam int HW  = lzss_pkg::HALF_W;

    typedef enum logic [1:0] {
        AWAIT_HDR_LO,
        AWAIT_HDR_HI,
        AWAIT_FLAGS,
        AWAIT_ITEM
    } stream_phase_t;

    typedef struct packed {
        logic [HW-1:0] halfword;
        logic          last;
    } halfword_beat_t;

    logic [HW-1:0]  history [WIN];
    stream_phase_t  phase;
    logic [7:0]     count_lo;
    logic [HW-1:0]  flag_word;
    logic [3:0]     flag_pos;
    logic [CW-1:0]  remaining;
    logic [CW-1:0]  produced;
    halfword_beat_t expected_beats [$];
    halfword_beat_t front_beat;

    task automatic emit_halfword(input logic [HW-1:0] value);
        halfword_beat_t beat;
        history[produced % WIN] = value;
        produced  = produced + 1'b1;
        remaining = remaining - 1'b1;
        beat.halfword = value;
        beat.last     = (remaining == 0);
        expected_beats.push_back(beat);
    endtask

    task automatic decode_halfword(input logic [HW-1:0] w);
        int            copy_len;
        int            distance;
        int            i;
        logic [HW-1:0] value;
        case (phase)
            AWAIT_HDR_LO:
            begin
                count_lo = w[15:8];
                phase    = AWAIT_HDR_HI;
            end
            AWAIT_HDR_HI:
            begin
                remaining = {w, count_lo};
                produced  = '0;
                flag_word = '0;
                flag_pos  = '0;
                phase     = (remaining == 0) ? AWAIT_HDR_LO : AWAIT_FLAGS;
            end
            AWAIT_FLAGS:
            begin
                flag_word = w;
                flag_pos  = '0;
                phase     = AWAIT_ITEM;
            end
            default:
            begin
                if (!flag_word[flag_pos])
                    emit_halfword(w);
                else
                begin
                    copy_len = int'(w[3:0]) + lzss_pkg::MIN_MATCH_DEF;
                    distance = int'(w[15:4]) + 1;
                    if (copy_len > remaining)
                        copy_len = remaining;
                    for (i = 0; i < copy_len; i++)
                    begin
                        // reaching back past the stream start gives zero
                        value = (distance <= produced)
                                ? history[(produced - distance) % WIN] : '0;
                        emit_halfword(value);
                    end
                end
                flag_pos = flag_pos + 1'b1;
                if (remaining == 0)
                begin
                    phase     = AWAIT_HDR_LO;
                    flag_pos  = '0;
                    flag_word = '0;
                end
                else if (flag_pos == 0)
                    phase = AWAIT_FLAGS;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase      = AWAIT_HDR_LO;
            count_lo   = '0;
            flag_word  = '0;
            flag_pos   = '0;
            remaining  = '0;
            produced   = '0;
            mismatches = 0;
            expected_beats.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                decode_halfword(in_halfword);
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected output item %h last %b",
                                 $realtime, out_halfword, out_last);
                    mismatches++;
                end
                else
                begin
                    front_beat = expected_beats.pop_front();
                    if (out_halfword !== front_beat.halfword || out_last !== front_beat.last)
                    begin
                        if (mismatches < 10)
                            $display("%0t: output item expected %h last %b, got %h last %b",
                                     $realtime, front_beat.halfword, front_beat.last,
                                     out_halfword, out_last);
                        mismatches++;
                    end
                end
            end
        end
        pending = expected_beats.size();
    end

endmodule

### tb/sv/tb.sv
// tb: clock, reset and stimulus for lzss_halfword_decompressor, plus the final verdict
// depends on lzss_pkg, the decompressor rtl and lzss_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN         = lzss_pkg::WINDOW_DEPTH_DEF;
    localparam int HW          = lzss_pkg::HALF_W;
    localparam int STALL_LIMIT = 5000;

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          in_valid    = 1'b0;
    logic          in_ready;
    logic [HW-1:0] in_halfword = '0;
    logic          out_valid;
    logic          out_ready   = 1'b0;
    logic [HW-1:0] out_halfword;
    logic          out_last;

    int pending;
    int mismatches;
    int send_idle_pct = 8;
    int recv_idle_pct = 82;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    lzss_halfword_decompressor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_halfword  (in_halfword),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_halfword (out_halfword),
        .out_last     (out_last)
    );

    lzss_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_halfword  (in_halfword),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_halfword (out_halfword),
        .out_last     (out_last),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    always #10ns clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** lzss_halfword_decompressor: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_halfword(input logic [HW-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        in_halfword <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic int pick_distance(input int unsigned produced_so_far);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 1;
        if (r < 20)
            return WIN;
        if (r < 35 || produced_so_far == 0)
            return $urandom_range(1, WIN);
        return $urandom_range(1, (produced_so_far < WIN) ? produced_so_far : WIN);
    endfunction

    function automatic int unsigned pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 15)
            return 1;
        if (r < 90)
            return $urandom_range(2, 48);
        return $urandom_range(49, 300);
    endfunction

    // well-formed stream with random content; stops early once out_budget halfwords are due
    task automatic send_stream(input int unsigned count, input int token_pct,
                               input int long_pct, input int unsigned out_budget);
        int unsigned   left;
        int unsigned   produced_so_far;
        int            b;
        int            distance;
        int            step;
        logic [HW-1:0] flags;
        logic [3:0]    len_field;
        left            = count;
        produced_so_far = 0;
        push_halfword({count[7:0], 8'($urandom)});
        push_halfword(count[23:8]);
        while (left > 0 && produced_so_far < out_budget)
        begin
            for (b = 0; b < 16; b++)
                flags[b] = ($urandom_range(0, 99) < token_pct);
            push_halfword(flags);
            for (b = 0; b < 16 && left > 0 && produced_so_far < out_budget; b++)
            begin
                if (flags[b])
                begin
                    len_field = ($urandom_range(0, 99) < long_pct) ? 4'hF : 4'($urandom);
                    distance  = pick_distance(produced_so_far);
                    push_halfword({12'(distance - 1), len_field});
                    step = int'(len_field) + lzss_pkg::MIN_MATCH_DEF;
                    if (step > left)
                        step = left;
                end
                else
                begin
                    push_halfword(16'($urandom));
                    step = 1;
                end
                left            -= step;
                produced_so_far += step;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero count with junk in the ignored header bits
        push_halfword(16'h00A5);
        push_halfword(16'h0000);
        // literal, overlapping copy of it, literal; the unused flag bits are dropped
        push_halfword(16'h05FF);
        push_halfword(16'h0000);
        push_halfword(16'hFFFA);
        push_halfword(16'hFFFF);
        push_halfword(16'h0000);
        push_halfword(16'h0000);
        // longest token at the farthest distance, all before the stream start, clipped
        push_halfword(16'h0400);
        push_halfword(16'h0000);
        push_halfword(16'h0003);
        push_halfword(16'hFFFF);
        // copy straddling the stream start, then a short copy clipped at the count
        push_halfword(16'h1400);
        push_halfword(16'h0000);
        push_halfword(16'h0006);
        push_halfword(16'h1234);
        push_halfword(16'h001F);
        push_halfword(16'h0005);

        while (items_sent < 30)
            send_stream(pick_count(), $urandom_range(10, 70), 20, 32'hFFFFFFFF);
        hold_until_drained();

        send_idle_pct = 82;
        recv_idle_pct = 8;
        while (items_sent < 50)
            send_stream(pick_count(), $urandom_range(10, 70), 20, 32'hFFFFFFFF);
        hold_until_drained();

        // largest count, run far enough for the history window to wrap
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_stream(32'h00FFFFFF, 100, 100, 4140);
        hold_until_drained();

        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("** lzss_halfword_decompressor: PASSED **");
        else
            $display("** lzss_halfword_decompressor: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/lzss_pkg.sv
rtl/lzss_ram.sv
rtl/lzss_halfword_decompressor.sv
tb/sv/lzss_checker.sv
tb/sv/tb.sv
